FILE: rtl/tps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tps_pkg;

    localparam logic [31:0] CLK_HZ_RESET = 32'd16000000;
    localparam logic [31:0] LIMIT_8BIT   = 32'h0000_00ff;
    localparam logic [31:0] LIMIT_16BIT  = 32'h0000_ffff;
    localparam int          DIV_STEPS    = 32;
    localparam logic [2:0]  LAST_T2      = 3'd6;
    localparam logic [2:0]  LAST_STD     = 3'd4;
    localparam logic [1:0]  TIMER_2      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } tps_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } tps_cmd_t;

    typedef struct packed {
        logic out_free;
    } tps_stat_t;

    // prescaler shift for slot idx; timer 2 has the longer list
    function automatic logic [3:0] prescale_shift(input logic is_t2, input logic [2:0] idx);
        logic [3:0] sh;
        sh = 4'd10;
        if (is_t2)
        begin
            unique case (idx)
                3'd0:    sh = 4'd0;
                3'd1:    sh = 4'd3;
                3'd2:    sh = 4'd5;
                3'd3:    sh = 4'd6;
                3'd4:    sh = 4'd7;
                3'd5:    sh = 4'd8;
                default: sh = 4'd10;
            endcase
        end
        else
        begin
            unique case (idx)
                3'd0:    sh = 4'd0;
                3'd1:    sh = 4'd3;
                3'd2:    sh = 4'd6;
                3'd3:    sh = 4'd8;
                default: sh = 4'd10;
            endcase
        end
        return sh;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/timer_prescaler_top_select_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | tdata                                       | tuser
// s_axis    | in        | [31:0] wanted_hz                            | [1:0] timer_select
// m_axis    | out       | [15:0] top_value [26:16] divisor            | [0] out_of_range
//           |           | [29:27] clock_select [31:30] zero           |
// cfg       | in        | cfg_wdata = system_clock_hz, written on cfg_we
//
// Each request runs through accept, 32 steps of the bit-serial divider, result load.
// The divider is the one shared unit; prescaler trials all come from its quotient.
// A new request is taken as soon as the result sits in the output register.
// A stalled output holds the controller in its last state until the register frees.
// rst_n clears control state and sets system_clock_hz to 16 MHz.

module timer_prescaler_top_select_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // wanted_hz
    input  wire logic [1:0]  s_axis_tuser,   // timer_select
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // top_value, divisor, clock_select, zero pad
    output logic             m_axis_tuser    // out_of_range
);

    tps_pkg::tps_cmd_t  cmd;
    tps_pkg::tps_stat_t stat;
    logic [15:0] top_value;
    logic [10:0] divisor;
    logic [2:0]  clock_select;
    logic        out_of_range;

    tps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tps_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .timer_select (s_axis_tuser),
        .wanted_hz    (s_axis_tdata),
        .cmd          (cmd),
        .stat         (stat),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .top_value    (top_value),
        .divisor      (divisor),
        .clock_select (clock_select),
        .out_of_range (out_of_range)
    );

    assign m_axis_tdata = {2'b00, clock_select, divisor, top_value};
    assign m_axis_tuser = out_of_range;

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while divider busy");

    a_result_codes: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot(divisor) && clock_select != 3'd0)
        else $error("bad divisor or clock select");

    a_oor_max_div: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_of_range |-> divisor == 11'd1024)
        else $error("out of range without largest divisor");

    a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !m_axis_tvalid || m_axis_tready)
        else $error("result overwritten");

endmodule

`default_nettype wire

FILE: rtl/tps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tps_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire tps_pkg::tps_stat_t stat,
    output tps_pkg::tps_cmd_t   cmd
);

    tps_pkg::tps_state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tps_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            tps_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = tps_pkg::ST_DIV;
                end
            end
            tps_pkg::ST_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(tps_pkg::DIV_STEPS - 1))
                begin
                    state_next = tps_pkg::ST_DONE;
                end
            end
            tps_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = tps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tps_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/tps_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module tps_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [31:0]       cfg_wdata,
    input  wire logic [1:0]        timer_select,
    input  wire logic [31:0]       wanted_hz,
    input  wire tps_pkg::tps_cmd_t cmd,
    output tps_pkg::tps_stat_t     stat,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [15:0]            top_value,
    output logic [10:0]            divisor,
    output logic [2:0]             clock_select,
    output logic                   out_of_range
);

    logic [31:0] clk_hz_reg;
    logic [31:0] freq_reg;
    logic [1:0]  sel_reg;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic        out_valid_reg;
    logic [15:0] top_reg;
    logic [10:0] div_reg;
    logic [2:0]  cs_reg;
    logic        oor_reg;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        is_t2;
    logic [31:0] limit;
    logic [2:0]  last_idx;
    logic [6:0]  fits;
    logic [2:0]  chosen;
    logic        found;
    logic [3:0]  sh;
    logic [31:0] top_full;
    logic        freq_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg    <= tps_pkg::CLK_HZ_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                clk_hz_reg <= cfg_wdata;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // restoring divider, one quotient bit per step; dividend shifts out of quo_reg
    always_comb
    begin
        trial    = {rem_reg, quo_reg[31]};
        diff     = trial - {1'b0, freq_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (cmd.step)
        begin
            if (trial >= {1'b0, freq_reg})
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            freq_reg <= wanted_hz;
            sel_reg  <= timer_select;
            rem_reg  <= '0;
            quo_reg  <= clk_hz_reg;
        end
        else
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.finish)
        begin
            top_reg <= top_full[15:0];
            div_reg <= 11'd1 << sh;
            cs_reg  <= chosen + 3'd1;
            oor_reg <= !found;
        end
    end

    // (clk >> s) / f == (clk / f) >> s, so each prescaler trial is a shift of one quotient
    always_comb
    begin
        is_t2     = (sel_reg == tps_pkg::TIMER_2);
        limit     = sel_reg[0] ? tps_pkg::LIMIT_16BIT : tps_pkg::LIMIT_8BIT;
        last_idx  = is_t2 ? tps_pkg::LAST_T2 : tps_pkg::LAST_STD;
        freq_zero = (freq_reg == '0);
        for (int i = 0; i < 7; i++)
        begin
            fits[i] = ((quo_reg >> tps_pkg::prescale_shift(is_t2, 3'(i))) - 32'd1) <= limit;
        end
        chosen = last_idx;
        found  = 1'b0;
        for (int i = 6; i >= 0; i--)
        begin
            if (3'(i) <= last_idx && fits[i] && !freq_zero)
            begin
                chosen = 3'(i);
                found  = 1'b1;
            end
        end
        sh       = tps_pkg::prescale_shift(is_t2, chosen);
        top_full = freq_zero ? 32'hffff_ffff : (quo_reg >> sh) - 32'd1;
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign top_value     = top_reg;
    assign divisor       = div_reg;
    assign clock_select  = cs_reg;
    assign out_of_range  = oor_reg;

endmodule

`default_nettype wire

FILE: tb/tb_timer_prescaler_top_select_core.sv
`timescale 1ns / 1ps

module tb_timer_prescaler_top_select_core;

    localparam logic [1:0] TIMER_0 = 2'd0;
    localparam logic [1:0] TIMER_1 = 2'd1;
    localparam logic [1:0] TIMER_2 = tps_pkg::TIMER_2;
    localparam logic [1:0] TIMER_3 = 2'd3;

    localparam logic [2:0] CS_DIV1     = 3'd1;
    localparam logic [2:0] CS_STD_256  = 3'd4;
    localparam logic [2:0] CS_STD_1024 = 3'd5;
    localparam logic [2:0] CS_T2_1024  = 3'd7;

    localparam int unsigned T2_SHIFTS  [7] = '{0, 3, 5, 6, 7, 8, 10};
    localparam int unsigned STD_SHIFTS [5] = '{0, 3, 6, 8, 10};

    localparam int NUM_PHASES     = 8;
    localparam int RANDOM_PER_PH  = 241;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic [15:0] top;
        logic [10:0] divisor;
        logic [2:0]  csel;
        logic        oor;
    } prescale_t;

    typedef struct packed {
        logic [1:0]  sel;
        logic [31:0] hz;
        logic        typed;
        prescale_t   want;
    } dir_row_t;

    localparam int NUM_DIRECTED = 25;
    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        '{TIMER_0, 32'd0,          1'b1, '{16'hffff, 11'd1024, CS_STD_1024, 1'b1}},
        '{TIMER_1, 32'd0,          1'b1, '{16'hffff, 11'd1024, CS_STD_1024, 1'b1}},
        '{TIMER_2, 32'd0,          1'b1, '{16'hffff, 11'd1024, CS_T2_1024,  1'b1}},
        '{TIMER_3, 32'd0,          1'b1, '{16'hffff, 11'd1024, CS_STD_1024, 1'b1}},
        '{TIMER_1, 32'hffffffff,   1'b1, '{16'hffff, 11'd1024, CS_STD_1024, 1'b1}},
        '{TIMER_2, 32'hffffffff,   1'b1, '{16'hffff, 11'd1024, CS_T2_1024,  1'b1}},
        '{TIMER_3, 32'd16000001,   1'b1, '{16'hffff, 11'd1024, CS_STD_1024, 1'b1}},
        '{TIMER_0, 32'd16000000,   1'b1, '{16'd0,    11'd1,    CS_DIV1,     1'b0}},
        '{TIMER_2, 32'd16000000,   1'b1, '{16'd0,    11'd1,    CS_DIV1,     1'b0}},
        '{TIMER_1, 32'd1,          1'b1, '{16'd62499, 11'd256, CS_STD_256,  1'b0}},
        '{TIMER_0, 32'd1,          1'b1, '{16'd15624, 11'd1024, CS_STD_1024, 1'b1}},
        '{TIMER_2, 32'd1,          1'b1, '{16'd15624, 11'd1024, CS_T2_1024,  1'b1}},
        '{TIMER_2, 32'd2000,       1'b0, '0},
        '{TIMER_2, 32'd500,        1'b0, '0},
        '{TIMER_2, 32'd8000,       1'b0, '0},
        '{TIMER_2, 32'd1000,       1'b0, '0},
        '{TIMER_2, 32'd300,        1'b0, '0},
        '{TIMER_2, 32'd100,        1'b0, '0},
        '{TIMER_0, 32'd62500,      1'b0, '0},
        '{TIMER_0, 32'd8000,       1'b0, '0},
        '{TIMER_0, 32'd1000,       1'b0, '0},
        '{TIMER_3, 32'd245,        1'b0, '0},
        '{TIMER_3, 32'd50000,      1'b0, '0},
        '{TIMER_1, 32'h55555555,   1'b0, '0},
        '{TIMER_0, 32'haaaaaaaa,   1'b0, '0}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] wanted_hz
    logic [1:0]  s_axis_tuser;   // [1:0] timer_select
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [15:0] top, [26:16] divisor, [29:27] clock_select, pad
    logic        m_axis_tuser;   // [0] out_of_range

    prescale_t   expected_prescale_q [$];
    logic [31:0] clock_hz_shadow;
    int          src_idle_pct;
    int          sink_stall_pct;
    int          hold_reqs;
    int          errors;
    int          results_checked;
    int          requests_sent;

    timer_prescaler_top_select_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL timer_prescaler_top_select_core");
        $finish;
    end

    function automatic int unsigned shift_at(logic [1:0] sel, int idx);
        if (sel == TIMER_2)
            return T2_SHIFTS[idx];
        return STD_SHIFTS[idx];
    endfunction

    // first divisor whose top value fits the counter; 1024 is kept on failure
    function automatic prescale_t predict_prescale(logic [1:0] sel, logic [31:0] clk_hz,
                                                   logic [31:0] hz);
        prescale_t   r;
        logic [31:0] quot;
        logic [31:0] lim;
        int          n;
        int          i;
        int          pick;
        bit          miss;
        n    = (sel == TIMER_2) ? 7 : 5;
        lim  = sel[0] ? tps_pkg::LIMIT_16BIT : tps_pkg::LIMIT_8BIT;
        pick = n - 1;
        quot = 32'hffffffff;
        miss = 1'b1;
        if (hz != 32'd0)
        begin
            for (i = 0; i < n && miss; i++)
            begin
                quot = (clk_hz >> shift_at(sel, i)) / hz - 32'd1;
                pick = i;
                miss = (quot > lim);
            end
        end
        r.top     = quot[15:0];
        r.divisor = 11'(32'd1 << shift_at(sel, pick));
        r.csel    = 3'(pick + 1);
        r.oor     = miss;
        return r;
    endfunction

    function automatic logic [31:0] pick_wanted_hz(logic [1:0] sel, logic [31:0] clk_hz);
        int          kind;
        int          n;
        logic [31:0] lim;
        logic [31:0] base;
        kind = $urandom_range(0, 99);
        n    = (sel == TIMER_2) ? 7 : 5;
        lim  = sel[0] ? tps_pkg::LIMIT_16BIT : tps_pkg::LIMIT_8BIT;
        if (kind < 4)
            return 32'd0;
        if (kind < 14)
            return $urandom;
        if (kind < 22)
            return clk_hz + 32'($urandom_range(1, 1000));
        if (kind < 65)
        begin
            // land near the fit boundary of one divisor
            base = (clk_hz >> shift_at(sel, $urandom_range(0, n - 1))) / (lim + 32'd1);
            return base + 32'($urandom_range(0, 4)) - 32'd2;
        end
        return 32'($urandom_range(1, 70000));
    endfunction

    task automatic note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    task automatic send_request(input logic [1:0] sel, input logic [31:0] hz,
                                input bit typed, input prescale_t want);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < src_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= hz;
        s_axis_tuser  <= sel;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        expected_prescale_q.push_back(typed ? want : predict_prescale(sel, clock_hz_shadow, hz));
        requests_sent++;
    endtask

    task automatic drain_requests();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_prescale_q.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_clock_hz(input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        clock_hz_shadow = value;
    endtask

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen     = 0;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        prescale_t want;
        prescale_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tdata[15:0], m_axis_tdata[26:16], m_axis_tdata[29:27],
                    m_axis_tuser};
            if (expected_prescale_q.size() == 0)
                note_error($sformatf("unexpected result top=%0d div=%0d cs=%0d oor=%0d",
                                     got.top, got.divisor, got.csel, got.oor));
            else
            begin
                want = expected_prescale_q.pop_front();
                results_checked++;
                if (got.top != want.top || got.divisor != want.divisor ||
                    got.csel != want.csel || got.oor != want.oor ||
                    m_axis_tdata[31:30] != 2'b00)
                    note_error({$sformatf("mismatch #%0d: exp top=%0d div=%0d cs=%0d oor=%0d,",
                                          results_checked, want.top, want.divisor,
                                          want.csel, want.oor),
                                $sformatf(" got top=%0d div=%0d cs=%0d oor=%0d pad=%0d",
                                          got.top, got.divisor, got.csel, got.oor,
                                          m_axis_tdata[31:30])});
            end
        end
    end

    initial
    begin
        logic [31:0] clk_settings [NUM_PHASES];
        logic [1:0]  sel;
        int          p;
        int          k;
        clk_settings    = '{32'd16000000, 32'd1, 32'hffffffff, 32'd0,
                            $urandom, 32'd20000000, $urandom, 32'd8000000};
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = 32'd0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = 32'd0;
        s_axis_tuser    = 2'd0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        hold_reqs       = 0;
        errors          = 0;
        results_checked = 0;
        requests_sent   = 0;
        clock_hz_shadow = tps_pkg::CLK_HZ_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < NUM_DIRECTED; k++)
            send_request(DIRECTED[k].sel, DIRECTED[k].hz, DIRECTED[k].typed,
                         DIRECTED[k].want);
        drain_requests();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            write_clock_hz(clk_settings[p]);
            src_idle_pct   = (p % 4 == 1) ? 74 : (p % 4 == 3) ? 26 : 0;
            sink_stall_pct = (p % 4 == 2) ? 74 : (p % 4 == 3) ? 26 : 0;
            if (p == 5)
                hold_reqs++;
            for (k = 0; k < RANDOM_PER_PH; k++)
            begin
                sel = 2'($urandom_range(0, 3));
                send_request(sel, pick_wanted_hz(sel, clock_hz_shadow), 1'b0, '0);
            end
            drain_requests();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_prescale_q.size() != 0)
            note_error($sformatf("%0d results never arrived", expected_prescale_q.size()));
        $display("Ran %0d requests over %0d clock settings (incl. 0, 1, max), all four timers",
                 requests_sent, NUM_PHASES + 1);
        $display("Checked %0d results under stalls and a %0d-cycle output hold, %0d errors",
                 results_checked, HOLD_CYCLES, errors);
        if (errors == 0)
            $display("PASS timer_prescaler_top_select_core");
        else
            $display("FAIL timer_prescaler_top_select_core");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tps_pkg.sv
rtl/tps_ctrl.sv
rtl/tps_dp.sv
rtl/timer_prescaler_top_select_core.sv
tb/tb_timer_prescaler_top_select_core.sv
